[hdl/rled_pkg.sv]
// shared constants for the resistor ladder encoder and button decoder
package rled_pkg;

    // item kinds carried on s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVELS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVELS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS  = 2'd3;

    localparam int LEVELS_REG_W = 48;
    localparam int MS_REG_W     = 16;
    localparam int CFG_DATA_W   = 48;

    localparam logic [LEVELS_REG_W-1:0] LEVELS_LOW_RESET  = 48'd160148933402624;
    localparam logic [LEVELS_REG_W-1:0] LEVELS_HIGH_RESET = 48'd210055889414636;
    localparam logic [MS_REG_W-1:0]     DEBOUNCE_RESET    = 16'd20;
    localparam logic [MS_REG_W-1:0]     LONG_PRESS_RESET  = 16'd1000;

    localparam int ADC_BITS_DEFAULT = 12;
    localparam int NUM_LEVELS       = 8;
    localparam int LANES_PER_REG    = 4;
    localparam int CODE_W           = 3;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int HIST_W  = 12;

    // code history pattern matching
    localparam logic [HIST_W-1:0] PATTERN_MASK  = 12'hF0F;
    localparam logic [HIST_W-1:0] PATTERN_VALUE = 12'h300;
    localparam logic [HIST_W-1:0] MIDDLE_MASK   = 12'h0F0;
    localparam logic [HIST_W-1:0] MIDDLE_UP     = 12'h010;

    // result tdata: count, delta, pressed, short, long, padded to bytes
    localparam int M_FIELDS_W = 2 * COUNT_W + 3;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

[hdl/resistor_ladder_encoder_decoder_top.sv]
// resistor ladder rotary encoder and push button decoder, single pass datapath
//
// Usage: s_ items are either ADC samples (s_tuser = 0) carrying a 12-bit
// reading and a millisecond timestamp, or status reads (s_tuser = 1). Each
// sample is matched to the nearest of eight programmed ladder levels; the
// code counts only once two samples in a row agree. Bit 2 of the code is the
// button, debounced by time, with a long press flagged after the hold time
// and a short press flagged on a release without a long press. Bits 1:0
// drive the detent counter while the button is up. Every item yields exactly
// one m_ item carrying the count; a read also returns the move since the
// previous read and clears the pending press flags.
// An accepted item is held in the input register, then its result in the
// result register, which drives m_tvalid; one item is accepted per cycle
// while the result register is free, set by the single level-match and
// state-update pass between the two registers.
// The cfg_ port writes the level and timing registers at any edge with
// cfg_we high. aresetn (synchronous, active low) restores register defaults
// and clears all decoder state. While m_tvalid is high and m_tready is low,
// the result register holds, the input register fills, then s_tready drops.
module resistor_ladder_encoder_decoder_top #(
    parameter int ADC_BITS = rled_pkg::ADC_BITS_DEFAULT,
    localparam int S_DATA_W = ((ADC_BITS + rled_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [rled_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rled_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_DATA_W-1:0]                 s_tdata,  // adc_sample, time_ms, zero pad
    input  logic                                s_tuser,  // cmd
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rled_pkg::M_DATA_W-1:0]       m_tdata   // position_count, move_delta,
                                                          // pressed, short_seen, long_seen, pad
);

    localparam int TW = rled_pkg::TIME_W;
    localparam int CW = rled_pkg::COUNT_W;
    localparam int HW = rled_pkg::HIST_W;
    localparam int LW = rled_pkg::LEVELS_REG_W;
    localparam int EXT_W = LW + rled_pkg::LANES_PER_REG * ADC_BITS;

    typedef enum logic [1:0] {
        LONG_IDLE,
        LONG_PENDING,
        LONG_DONE
    } long_state_t;

    // configuration registers
    logic [LW-1:0]                   levels_low_reg;
    logic [LW-1:0]                   levels_high_reg;
    logic [rled_pkg::MS_REG_W-1:0]   debounce_reg;
    logic [rled_pkg::MS_REG_W-1:0]   long_press_reg;

    // input register
    logic                  in_valid_reg;
    logic                  cmd_reg;
    logic [ADC_BITS-1:0]   sample_reg;
    logic [TW-1:0]         time_ms_reg;

    // decoder state
    logic [rled_pkg::CODE_W-1:0] prev_code_reg, prev_code_next;
    logic                        raw_button_reg, raw_button_next;
    logic                        stable_button_reg, stable_button_next;
    logic [TW-1:0]               change_stamp_reg, change_stamp_next;
    logic [TW-1:0]               press_stamp_reg, press_stamp_next;
    long_state_t                 long_state_reg, long_state_next;
    logic                        short_pending_reg, short_pending_next;
    logic [HW-1:0]               code_history_reg, code_history_next;
    logic [CW-1:0]               detent_count_reg, detent_count_next;
    logic [CW-1:0]               count_at_read_reg, count_at_read_next;

    // result register
    logic                  m_valid_reg;
    logic [CW-1:0]         out_count_reg;
    logic [CW-1:0]         out_delta_reg, out_delta_next;
    logic                  out_pressed_reg;
    logic                  out_short_reg, out_short_next;
    logic                  out_long_reg, out_long_next;

    logic out_free;
    logic advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // level lanes, bits past the register read as zero
    logic [EXT_W-1:0]    low_ext;
    logic [EXT_W-1:0]    high_ext;
    logic [ADC_BITS-1:0] level [rled_pkg::NUM_LEVELS];

    assign low_ext  = {{(EXT_W - LW){1'b0}}, levels_low_reg};
    assign high_ext = {{(EXT_W - LW){1'b0}}, levels_high_reg};

    for (genvar g = 0; g < rled_pkg::NUM_LEVELS; g++) begin : g_level
        if (g < rled_pkg::LANES_PER_REG) begin : g_low
            assign level[g] = low_ext[(g % rled_pkg::LANES_PER_REG) * ADC_BITS +: ADC_BITS];
        end else begin : g_high
            assign level[g] = high_ext[(g % rled_pkg::LANES_PER_REG) * ADC_BITS +: ADC_BITS];
        end
    end

    // nearest level, first minimum wins on a tie
    logic [rled_pkg::CODE_W-1:0] code;
    always_comb begin
        logic [ADC_BITS-1:0] lvl_diff;
        logic [ADC_BITS-1:0] best_diff;
        code      = '0;
        best_diff = '0;
        for (int i = 0; i < rled_pkg::NUM_LEVELS; i++) begin
            lvl_diff = (level[i] > sample_reg) ? level[i] - sample_reg
                                               : sample_reg - level[i];
            if (i == 0 || lvl_diff < best_diff) begin
                best_diff = lvl_diff;
                code      = rled_pkg::CODE_W'(i);
            end
        end
    end

    // elapsed times since the stamps, as signed 32-bit
    logic [TW-1:0] since_change;
    logic [TW-1:0] since_press;
    logic          debounce_done;
    logic          hold_long;

    assign since_change  = time_ms_reg - change_stamp_reg;
    assign since_press   = time_ms_reg - press_stamp_reg;
    assign debounce_done = !since_change[TW-1] && (since_change >= {16'd0, debounce_reg});
    assign hold_long     = !since_press[TW-1] && (since_press > {16'd0, long_press_reg});

    always_comb begin
        logic [HW-1:0] hist_shift;
        prev_code_next     = prev_code_reg;
        raw_button_next    = raw_button_reg;
        stable_button_next = stable_button_reg;
        change_stamp_next  = change_stamp_reg;
        press_stamp_next   = press_stamp_reg;
        long_state_next    = long_state_reg;
        short_pending_next = short_pending_reg;
        code_history_next  = code_history_reg;
        detent_count_next  = detent_count_reg;
        count_at_read_next = count_at_read_reg;
        out_delta_next     = '0;
        out_short_next     = 1'b0;
        out_long_next      = 1'b0;
        hist_shift         = {code_history_reg[HW-5:0], 2'b00, code[1:0]};

        if (cmd_reg == rled_pkg::CMD_SAMPLE) begin
            if (prev_code_reg != code) begin
                prev_code_next = code;
            end else begin
                // button path
                if (raw_button_reg != code[2]) begin
                    raw_button_next   = code[2];
                    change_stamp_next = time_ms_reg;
                    press_stamp_next  = time_ms_reg;
                end else if (debounce_done) begin
                    if (stable_button_reg != raw_button_reg) begin
                        stable_button_next = raw_button_reg;
                        if (raw_button_reg) begin
                            long_state_next = LONG_IDLE;
                        end else if (long_state_reg == LONG_IDLE) begin
                            short_pending_next = 1'b1;
                        end
                    end
                    if (stable_button_next && hold_long && long_state_next == LONG_IDLE) begin
                        long_state_next = LONG_PENDING;
                    end
                end
                // rotation path, only with the button up
                if (!code[2] && code_history_reg[1:0] != code[1:0]) begin
                    code_history_next = hist_shift;
                    if ((hist_shift & rled_pkg::PATTERN_MASK) == rled_pkg::PATTERN_VALUE) begin
                        if ((hist_shift & rled_pkg::MIDDLE_MASK) == rled_pkg::MIDDLE_UP) begin
                            detent_count_next = detent_count_reg + CW'(1);
                        end else begin
                            detent_count_next = detent_count_reg - CW'(1);
                        end
                    end
                end
            end
        end else begin
            out_delta_next     = detent_count_reg - count_at_read_reg;
            count_at_read_next = detent_count_reg;
            out_short_next     = short_pending_reg;
            out_long_next      = (long_state_reg == LONG_PENDING);
            if (short_pending_reg || long_state_reg == LONG_PENDING) begin
                short_pending_next = 1'b0;
                long_state_next    = LONG_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_low_reg  <= rled_pkg::LEVELS_LOW_RESET;
            levels_high_reg <= rled_pkg::LEVELS_HIGH_RESET;
            debounce_reg    <= rled_pkg::DEBOUNCE_RESET;
            long_press_reg  <= rled_pkg::LONG_PRESS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rled_pkg::CFG_LEVELS_LOW:  levels_low_reg  <= cfg_wdata[LW-1:0];
                rled_pkg::CFG_LEVELS_HIGH: levels_high_reg <= cfg_wdata[LW-1:0];
                rled_pkg::CFG_DEBOUNCE:    debounce_reg    <= cfg_wdata[rled_pkg::MS_REG_W-1:0];
                rled_pkg::CFG_LONG_PRESS:  long_press_reg  <= cfg_wdata[rled_pkg::MS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg     <= s_tuser;
            sample_reg  <= s_tdata[ADC_BITS-1:0];
            time_ms_reg <= s_tdata[ADC_BITS +: TW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg     <= '0;
            raw_button_reg    <= 1'b0;
            stable_button_reg <= 1'b0;
            change_stamp_reg  <= '0;
            press_stamp_reg   <= '0;
            long_state_reg    <= LONG_IDLE;
            short_pending_reg <= 1'b0;
            code_history_reg  <= '0;
            detent_count_reg  <= '0;
            count_at_read_reg <= '0;
            m_valid_reg       <= 1'b0;
            out_count_reg     <= '0;
            out_delta_reg     <= '0;
            out_pressed_reg   <= 1'b0;
            out_short_reg     <= 1'b0;
            out_long_reg      <= 1'b0;
        end else begin
            if (advance) begin
                prev_code_reg     <= prev_code_next;
                raw_button_reg    <= raw_button_next;
                stable_button_reg <= stable_button_next;
                change_stamp_reg  <= change_stamp_next;
                press_stamp_reg   <= press_stamp_next;
                long_state_reg    <= long_state_next;
                short_pending_reg <= short_pending_next;
                code_history_reg  <= code_history_next;
                detent_count_reg  <= detent_count_next;
                count_at_read_reg <= count_at_read_next;
                m_valid_reg       <= 1'b1;
                out_count_reg     <= detent_count_next;
                out_delta_reg     <= out_delta_next;
                out_pressed_reg   <= stable_button_next;
                out_short_reg     <= out_short_next;
                out_long_reg      <= out_long_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rled_pkg::M_DATA_W - rled_pkg::M_FIELDS_W){1'b0}},
                       out_long_reg, out_short_reg, out_pressed_reg,
                       out_delta_reg, out_count_reg};

endmodule
